### src/sb2dd_pkg.sv
// shared constants and types for the signed binary to decimal converter
package sb2dd_pkg;

  localparam int VALUE_BITS  = 128;
  localparam int DIGIT_COUNT = 39;

  localparam int BIT_W = $clog2(VALUE_BITS);
  localparam int REM_W = $clog2(DIGIT_COUNT + 1);

  localparam logic [BIT_W-1:0] BIT_CNT_INIT = BIT_W'(VALUE_BITS - 1);
  localparam logic [REM_W-1:0] REM_FULL     = REM_W'(DIGIT_COUNT);
  localparam logic [REM_W-1:0] REM_ONE      = REM_W'(1);

  localparam logic [3:0] DIGIT_FIVE = 4'd5;

  // per-cycle command to every digit cell
  typedef struct packed {
    logic clear;
    logic dabble;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SIGN = 5'b00100,
    ST_SKIP = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

endpackage

### src/sb2dd_digit_cell.sv
// one decimal digit of the conversion chain: clear, double and add, or shift along
module sb2dd_digit_cell (
  input  logic                  clk_i,
  input  sb2dd_pkg::cell_ctrl_t ctrl_i,
  input  logic                  carry_i,
  input  logic [3:0]            digit_i,
  output logic                  carry_o,
  output logic [3:0]            digit_o
);
  import sb2dd_pkg::*;

  logic [3:0] digit_q;
  logic [3:0] digit_d;
  logic [3:0] less_five;
  logic       ge_five;

  // 2d + c >= 10 exactly when d >= 5, so the carry out never waits on the carry in
  assign ge_five   = (digit_q >= DIGIT_FIVE);
  assign less_five = digit_q - DIGIT_FIVE;
  assign carry_o   = ge_five;
  assign digit_o   = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = 4'd0;
    end else if (ctrl_i.dabble) begin
      digit_d = ge_five ? {less_five[2:0], carry_i} : {digit_q[2:0], carry_i};
    end else if (ctrl_i.shift) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

### src/signed_binary_to_decimal_digits.sv
// top level: signed binary value in, decimal digit words out
//
//  channel  dir  fields (low bit up)                           end marker
//  s_axis   in   tdata: value_high[63:0], value_low[127:64]     -
//  m_axis   out  tdata: digit[3:0], zero pad; tuser: is_minus   tlast: last
//
// one value goes through an accept, a double-and-add step through the digit cell
// row for each value bit, a minus sign word for a negative value, then shifts of
// the row toward the top cell that skip leading zeros and emit digits. a stalled
// output holds the conversion in its sign or digit step until the word is taken.
// reset clears control and the output valid; digit cells are cleared on accept.
module signed_binary_to_decimal_digits (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // value_high[63:0], value_low[127:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,  // digit[3:0], zeros[7:4]
  output logic         m_axis_tuser,  // is_minus[0]
  output logic         m_axis_tlast
);
  import sb2dd_pkg::*;

  state_e state_q, state_d;
  logic [BIT_W-1:0]      bit_cnt_q, bit_cnt_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic                  neg_q, neg_d;

  logic       out_valid_q, out_valid_d;
  logic [3:0] out_digit_q, out_digit_d;
  logic       out_minus_q, out_minus_d;
  logic       out_last_q, out_last_d;

  logic [127:0]          full_value;
  logic [VALUE_BITS-1:0] in_value;
  logic                  in_neg;
  logic                  in_accept;
  logic                  slot_free;

  cell_ctrl_t ctrl;
  logic [DIGIT_COUNT:0]  carry;
  logic [3:0]            digit_in  [DIGIT_COUNT];
  logic [3:0]            digit_out [DIGIT_COUNT];
  logic [3:0]            top_digit;

  assign full_value = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
  assign in_value   = full_value[VALUE_BITS-1:0];
  assign in_neg     = in_value[VALUE_BITS-1];
  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign slot_free  = !out_valid_q || m_axis_tready;
  assign top_digit  = digit_out[DIGIT_COUNT-1];

  assign carry[0] = mag_q[VALUE_BITS-1];

  for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign digit_in[k] = 4'd0;
    end else begin : g_rest
      assign digit_in[k] = digit_out[k-1];
    end
    sb2dd_digit_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .carry_i (carry[k]),
      .digit_i (digit_in[k]),
      .carry_o (carry[k+1]),
      .digit_o (digit_out[k])
    );
  end

  always_comb begin
    state_d     = state_q;
    bit_cnt_d   = bit_cnt_q;
    rem_d       = rem_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_digit_d = out_digit_q;
    out_minus_d = out_minus_q;
    out_last_d  = out_last_q;
    ctrl        = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          mag_d      = in_neg ? (~in_value + 1'b1) : in_value;
          neg_d      = in_neg;
          bit_cnt_d  = BIT_CNT_INIT;
          ctrl.clear = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.dabble = 1'b1;
        mag_d       = {mag_q[VALUE_BITS-2:0], 1'b0};
        bit_cnt_d   = bit_cnt_q - 1'b1;
        if (bit_cnt_q == '0) begin
          rem_d   = REM_FULL;
          state_d = neg_q ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_minus_d = 1'b1;
          out_digit_d = 4'd0;
          out_last_d  = 1'b0;
          state_d     = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keep at least the units digit
        if (top_digit == 4'd0 && rem_q != REM_ONE) begin
          ctrl.shift = 1'b1;
          rem_d      = rem_q - 1'b1;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_minus_d = 1'b0;
          out_digit_d = top_digit;
          out_last_d  = (rem_q == REM_ONE);
          if (rem_q == REM_ONE) begin
            state_d = ST_IDLE;
          end else begin
            ctrl.shift = 1'b1;
            rem_d      = rem_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_cnt_q   <= '0;
      rem_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      rem_q       <= rem_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    out_digit_q <= out_digit_d;
    out_minus_q <= out_minus_d;
    out_last_q  <= out_last_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_digit_q};
  assign m_axis_tuser  = out_minus_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### src/sb2dd_checker.sv
// port-level checks for the converter, bound to the top level
module sb2dd_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [127:0] s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [7:0]   m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         m_axis_tlast
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output word changed under stall");

  // a digit word carries 0..9 with zero padding
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[3:0] <= 4'd9) && (m_axis_tdata[7:4] == 4'd0))
    else $error("digit out of range");

  // the minus sign is never the final word and carries digit zero
  a_minus_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast && (m_axis_tdata == 8'd0))
    else $error("malformed minus sign word");

  // while a value still has words to come, no new value is taken
  a_busy_mid_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready in the middle of a value");

  // after an accept the conversion runs before the next accept
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after accept");

endmodule

bind signed_binary_to_decimal_digits sb2dd_checker u_sb2dd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
